>>> rtl/lcp_pkg.sv
`default_nettype none

package lcp_pkg;

   // request kinds carried on req_tuser
   localparam logic ACTION_RESPONSE = 1'b0;
   localparam logic ACTION_TICK     = 1'b1;

   // panel response codes
   localparam logic [7:0] FAN_DOWN_CODE      = 8'h3D;
   localparam logic [7:0] FAN_UP_CODE        = 8'h3C;
   localparam logic [7:0] DEFROST_PRESS_CODE = 8'h40;
   localparam logic [7:0] LEFT_KNOB_CENTER   = 8'h10;
   localparam logic [7:0] RIGHT_KNOB_CENTER  = 8'h90;
   localparam logic [7:0] BUTTON_RELEASED    = 8'h00;

   // state reset values and limits
   localparam logic [7:0] TEMP_RESET = 8'h0D;
   localparam logic [2:0] FAN_MAX    = 3'd7;

   // bus bytes
   localparam logic [7:0] SYNC_BYTE    = 8'h55;
   localparam logic [7:0] STATUS_PID   = 8'hB1;
   localparam logic [7:0] REQUEST_PID  = 8'h39;
   localparam logic [7:0] DATA0_BYTE   = 8'h80;
   localparam logic [7:0] FAN_BASE     = 8'h20;
   localparam logic [7:0] DATA2_BYTE   = 8'h14;
   localparam logic [7:0] DEFROST_ON   = 8'h40;
   localparam logic [7:0] DEFROST_OFF  = 8'h00;
   localparam logic [7:0] DATA6_BYTE   = 8'h00;
   localparam logic [7:0] DATA7_BYTE   = 8'hC1;

   // snapshot queue
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // state seen by one tick
   typedef struct packed {
      logic [2:0] fan_level;
      logic       rear_defrost_on;
      logic [7:0] left_temp;
      logic [7:0] right_temp;
   } snap_type;

   // position of a byte within the tick's run
   typedef enum logic [3:0] {
      IDX_SYNC,
      IDX_PID,
      IDX_D0,
      IDX_D1,
      IDX_D2,
      IDX_D3,
      IDX_D4,
      IDX_D5,
      IDX_D6,
      IDX_D7,
      IDX_CHK,
      IDX_HSYNC,
      IDX_HPID
   } byte_idx_type;

   // fan pwm duty per mille: 800*level/7 + 200, zero when off
   function automatic logic [9:0] duty_of(input logic [2:0] lvl);
      logic [9:0] d;
      case (lvl)
         3'd0:    d = 10'd0;
         3'd1:    d = 10'd314;
         3'd2:    d = 10'd428;
         3'd3:    d = 10'd542;
         3'd4:    d = 10'd657;
         3'd5:    d = 10'd771;
         3'd6:    d = 10'd885;
         default: d = 10'd1000;
      endcase
      return d;
   endfunction

endpackage

`default_nettype wire

>>> rtl/lcp_queue.sv
`default_nettype none

module lcp_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push_valid,
   input  wire lcp_pkg::snap_type push_data,
   output logic                   full,
   output logic                   pop_valid,
   input  wire logic              pop_ready,
   output lcp_pkg::snap_type      pop_data
);
   import lcp_pkg::*;

   snap_type            mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                do_push, do_pop;

   assign full      = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_data  = mem_ff[rd_ptr_ff];
   assign do_push   = push_valid && !full;
   assign do_pop    = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

`ifndef NO_ASSERTIONS
   // front end must never push into a full queue
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push_valid && full))
      else $error("snapshot pushed into full queue");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("queue count out of range");
`endif

endmodule

`default_nettype wire

>>> rtl/lcp_front.sv
`default_nettype none

module lcp_front (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [31:0]  req_tdata,
   input  wire logic         req_tuser,
   output logic              push_valid,
   output lcp_pkg::snap_type push_data,
   input  wire logic         queue_full
);
   import lcp_pkg::*;

   logic [7:0] left_temp_ff,  left_temp_in;
   logic [7:0] right_temp_ff, right_temp_in;
   logic       defrost_ff,    defrost_in;
   logic [2:0] fan_level_ff,  fan_level_in;
   logic [7:0] prev_fan_ff,   prev_fan_in;
   logic [7:0] prev_def_ff,   prev_def_in;

   logic       req_fire;
   logic [7:0] fan_code, def_code, left_code, right_code;

   // step of plus or minus one to three around the knob's center code
   function automatic logic [7:0] knob_step(input logic [7:0] t, input logic [7:0] code,
                                            input logic [7:0] center);
      logic [7:0] up_d, dn_d, r;
      up_d = code - center;
      dn_d = center - code;
      if (up_d >= 8'd1 && up_d <= 8'd3) begin
         r = t + up_d;
      end else if (dn_d >= 8'd1 && dn_d <= 8'd3) begin
         r = t - dn_d;
      end else begin
         r = t;
      end
      return r;
   endfunction

   assign fan_code   = req_tdata[7:0];
   assign def_code   = req_tdata[15:8];
   assign left_code  = req_tdata[23:16];
   assign right_code = req_tdata[31:24];

   assign req_tready = !queue_full;
   assign req_fire   = req_tvalid && req_tready;
   assign push_valid = req_fire && (req_tuser == ACTION_TICK);

   assign push_data.fan_level       = fan_level_ff;
   assign push_data.rear_defrost_on = defrost_ff;
   assign push_data.left_temp       = left_temp_ff;
   assign push_data.right_temp      = right_temp_ff;

   always_comb begin
      left_temp_in  = left_temp_ff;
      right_temp_in = right_temp_ff;
      defrost_in    = defrost_ff;
      fan_level_in  = fan_level_ff;
      prev_fan_in   = prev_fan_ff;
      prev_def_in   = prev_def_ff;
      if (req_fire && (req_tuser == ACTION_RESPONSE)) begin
         right_temp_in = knob_step(right_temp_ff, right_code, RIGHT_KNOB_CENTER);
         left_temp_in  = knob_step(left_temp_ff, left_code, LEFT_KNOB_CENTER);
         if (def_code == DEFROST_PRESS_CODE && prev_def_ff == BUTTON_RELEASED) begin
            defrost_in = !defrost_ff;
         end
         if (fan_code == FAN_DOWN_CODE && prev_fan_ff == BUTTON_RELEASED &&
             fan_level_ff != 3'd0) begin
            fan_level_in = fan_level_ff - 3'd1;
         end else if (fan_code == FAN_UP_CODE && prev_fan_ff == BUTTON_RELEASED &&
                      fan_level_ff != FAN_MAX) begin
            fan_level_in = fan_level_ff + 3'd1;
         end
         prev_fan_in = fan_code;
         prev_def_in = def_code;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_temp_ff  <= TEMP_RESET;
         right_temp_ff <= TEMP_RESET;
         defrost_ff    <= 1'b0;
         fan_level_ff  <= 3'd0;
         prev_fan_ff   <= 8'd0;
         prev_def_ff   <= 8'd0;
      end else begin
         left_temp_ff  <= left_temp_in;
         right_temp_ff <= right_temp_in;
         defrost_ff    <= defrost_in;
         fan_level_ff  <= fan_level_in;
         prev_fan_ff   <= prev_fan_in;
         prev_def_ff   <= prev_def_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/lcp_back.sv
`default_nettype none

module lcp_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              pop_valid,
   output logic                   pop_ready,
   input  wire lcp_pkg::snap_type pop_data,
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   output logic [23:0]            rsp_tdata,
   output logic                   rsp_tuser,
   output logic                   rsp_tlast
);
   import lcp_pkg::*;

   logic         busy_ff, busy_in;
   byte_idx_type idx_ff,  idx_in;
   snap_type     snap_ff;
   logic [7:0]   acc_ff,  acc_in;

   logic       out_fire, run_done, load;
   logic [7:0] cur_byte;
   logic [8:0] sum9;
   logic       in_sum;

   assign out_fire  = busy_ff && rsp_tready;
   assign run_done  = out_fire && (idx_ff == IDX_HPID);
   assign pop_ready = !busy_ff || run_done;
   assign load      = pop_valid && pop_ready;

   // byte for the current position
   always_comb begin
      unique case (idx_ff)
         IDX_SYNC:  cur_byte = SYNC_BYTE;
         IDX_PID:   cur_byte = STATUS_PID;
         IDX_D0:    cur_byte = DATA0_BYTE;
         IDX_D1:    cur_byte = FAN_BASE | {5'd0, snap_ff.fan_level};
         IDX_D2:    cur_byte = DATA2_BYTE;
         IDX_D3:    cur_byte = snap_ff.rear_defrost_on ? DEFROST_ON : DEFROST_OFF;
         IDX_D4:    cur_byte = snap_ff.left_temp;
         IDX_D5:    cur_byte = snap_ff.right_temp;
         IDX_D6:    cur_byte = DATA6_BYTE;
         IDX_D7:    cur_byte = DATA7_BYTE;
         IDX_CHK:   cur_byte = ~acc_ff;
         IDX_HSYNC: cur_byte = SYNC_BYTE;
         IDX_HPID:  cur_byte = REQUEST_PID;
         default:   cur_byte = SYNC_BYTE;
      endcase
   end

   // enhanced checksum: pid and data bytes, carry folded back in
   assign in_sum = (idx_ff != IDX_SYNC) && (idx_ff != IDX_CHK) &&
                   (idx_ff != IDX_HSYNC) && (idx_ff != IDX_HPID);
   assign sum9   = {1'b0, acc_ff} + {1'b0, cur_byte};

   always_comb begin
      busy_in = busy_ff;
      idx_in  = idx_ff;
      acc_in  = acc_ff;
      if (out_fire) begin
         idx_in = byte_idx_type'(idx_ff + 4'd1);
         if (in_sum) begin
            acc_in = sum9[7:0] + {7'd0, sum9[8]};
         end
      end
      if (run_done) begin
         busy_in = 1'b0;
      end
      if (load) begin
         busy_in = 1'b1;
         idx_in  = IDX_SYNC;
         acc_in  = 8'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= IDX_SYNC;
         acc_ff  <= 8'd0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
         acc_ff  <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         snap_ff <= pop_data;
      end
   end

   assign rsp_tvalid = busy_ff;
   assign rsp_tdata  = {6'd0, duty_of(snap_ff.fan_level), cur_byte};
   assign rsp_tuser  = (idx_ff == IDX_SYNC) || (idx_ff == IDX_HSYNC);
   assign rsp_tlast  = (idx_ff == IDX_HPID);

`ifndef NO_ASSERTIONS
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (idx_ff <= IDX_HPID))
      else $error("byte position past end of run");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !rsp_tready) |=> ($stable(idx_ff) && $stable(acc_ff) && busy_ff))
      else $error("run advanced while output stalled");

   a_run_ends: assert property (@(posedge clock) disable iff (reset)
      (run_done && !pop_valid) |=> !busy_ff)
      else $error("back end still busy after final byte");

   a_new_run: assert property (@(posedge clock) disable iff (reset)
      load |=> (busy_ff && idx_ff == IDX_SYNC && acc_ff == 8'd0))
      else $error("new run did not start at sync byte");
`endif

endmodule

`default_nettype wire

>>> rtl/lin_climate_panel_master.sv
// LIN master for a climate control panel. Each request is either a panel
// response (req_tuser = 0), whose fan, defrost and knob codes update the fan
// level, rear defrost and both temperature settings when accepted and give no
// result, or a send tick (req_tuser = 1), which gives a run of 13 result bytes:
// the status frame (sync, PID 0xB1, eight data bytes, inverted enhanced
// checksum) and then the request header (sync, PID 0x39). rsp_tuser marks the
// two sync bytes that follow a bus break, rsp_tlast the final byte of a run,
// and every byte carries the fan pwm duty (per mille) of the level the tick saw.
// The front end takes one request per cycle while the queue is not full; a
// tick stores a copy of the state in a two-entry queue, so responses that
// arrive later never change a run already scheduled. The back end emits one
// byte per cycle while rsp_tready is high; requests stall only while both
// queue entries are waiting behind the run in progress.

`default_nettype none

module lin_climate_panel_master (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // fan_button_code, defrost_button_code, left_knob_code, right_knob_code
   input  wire logic [31:0] req_tdata,
   // action
   input  wire logic        req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // tx_byte, fan_duty, zero fill
   output logic [23:0]      rsp_tdata,
   // frame_start
   output logic             rsp_tuser,
   output logic             rsp_tlast
);
   import lcp_pkg::*;

   // front to queue
   logic     push_valid;
   snap_type push_data;
   logic     queue_full;

   // queue to back
   logic     pop_valid;
   logic     pop_ready;
   snap_type pop_data;

   // request intake and state update
   lcp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .push_valid (push_valid),
      .push_data  (push_data),
      .queue_full (queue_full)
   );

   // pending tick snapshots
   lcp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .full       (queue_full),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   // frame byte sequencer and checksum
   lcp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

>>> tb/sv/lin_climate_panel_master_test.sv
`timescale 1ns / 1ps

module lin_climate_panel_master_test;
   import lcp_pkg::*;

   // one bus byte as it leaves the block
   typedef struct packed {
      logic [7:0] tx_byte;
      logic       frame_start;
      logic [9:0] fan_duty;
      logic       last;
   } bus_byte_type;

   // one directed request; on ticks marked typed the panel state seen by the
   // status frame is written out by hand and replaces the predicted bytes
   typedef struct packed {
      logic       action;
      logic [7:0] fan;
      logic [7:0] defrost;
      logic [7:0] left_knob;
      logic [7:0] right_knob;
      logic       typed;
      logic [2:0] level;
      logic       defrost_on;
      logic [7:0] left_t;
      logic [7:0] right_t;
      logic [9:0] duty;
   } panel_row_type;

   localparam int RUN_BYTES    = 13;
   localparam int RANDOM_ITEMS = 113;
   localparam int LONG_HOLD    = 250;   // receiver hold-off to back up the tick queue
   localparam int HOLD_AFTER   = 120;   // bytes received before the hold-off starts
   localparam int DRAIN_CYCLES = 40;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   // fan_button_code, defrost_button_code, left_knob_code, right_knob_code
   logic [31:0] req_tdata  = '0;
   logic        req_tuser  = ACTION_RESPONSE;   // action
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;         // tx_byte, fan_duty, zero fill
   logic        rsp_tuser;         // frame_start
   logic        rsp_tlast;

   lin_climate_panel_master u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // panel state as the predictor tracks it
   logic [7:0] left_setting      = TEMP_RESET;
   logic [7:0] right_setting     = TEMP_RESET;
   logic       defrost_on        = 1'b0;
   logic [2:0] fan_level_now     = 3'd0;
   logic [7:0] prev_fan_code     = BUTTON_RELEASED;
   logic [7:0] prev_defrost_code = BUTTON_RELEASED;

   bus_byte_type expected_bytes[$];
   bus_byte_type want;

   int mismatch_count = 0;
   int bytes_seen     = 0;
   int ticks_sent     = 0;
   int responses_sent = 0;
   int temp_wraps     = 0;
   int top_level      = 0;
   int defrost_flips  = 0;
   bit hold_done      = 0;

   // directed part: reset values, every knob step both ways, button edges,
   // held and unknown codes, fan clamp at zero, ignored fields on ticks
   panel_row_type directed_rows [0:16] = '{
      // tick straight after reset
      '{ACTION_TICK, 8'h00, 8'h00, 8'h00, 8'h00,
        1'b1, 3'd0, 1'b0, 8'h0D, 8'h0D, 10'd0},
      // fan down at level zero is dropped, defrost edge turns it on
      '{ACTION_RESPONSE, FAN_DOWN_CODE, DEFROST_PRESS_CODE,
        LEFT_KNOB_CENTER + 8'd3, RIGHT_KNOB_CENTER - 8'd3,
        1'b0, 3'd0, 1'b0, 8'h00, 8'h00, 10'd0},
      // defrost held, no second toggle
      '{ACTION_RESPONSE, BUTTON_RELEASED, DEFROST_PRESS_CODE,
        LEFT_KNOB_CENTER + 8'd2, RIGHT_KNOB_CENTER - 8'd2,
        1'b0, 3'd0, 1'b0, 8'h00, 8'h00, 10'd0},
      // tick with all code fields high, which it must ignore
      '{ACTION_TICK, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
        1'b1, 3'd0, 1'b1, 8'h12, 8'h08, 10'd0},
      '{ACTION_RESPONSE, FAN_UP_CODE, BUTTON_RELEASED,
        LEFT_KNOB_CENTER + 8'd1, RIGHT_KNOB_CENTER - 8'd1,
        1'b0, 3'd0, 1'b0, 8'h00, 8'h00, 10'd0},
      // fan up held, defrost edge turns it off
      '{ACTION_RESPONSE, FAN_UP_CODE, DEFROST_PRESS_CODE,
        LEFT_KNOB_CENTER - 8'd1, RIGHT_KNOB_CENTER + 8'd1,
        1'b0, 3'd0, 1'b0, 8'h00, 8'h00, 10'd0},
      '{ACTION_RESPONSE, BUTTON_RELEASED, BUTTON_RELEASED,
        LEFT_KNOB_CENTER - 8'd2, RIGHT_KNOB_CENTER + 8'd2,
        1'b0, 3'd0, 1'b0, 8'h00, 8'h00, 10'd0},
      // unknown defrost code is stored as the previous code
      '{ACTION_RESPONSE, FAN_UP_CODE, DEFROST_PRESS_CODE + 8'd1,
        LEFT_KNOB_CENTER - 8'd3, RIGHT_KNOB_CENTER + 8'd3,
        1'b0, 3'd0, 1'b0, 8'h00, 8'h00, 10'd0},
      // defrost press without a release in between, knobs at center
      '{ACTION_RESPONSE, BUTTON_RELEASED, DEFROST_PRESS_CODE,
        LEFT_KNOB_CENTER, RIGHT_KNOB_CENTER,
        1'b0, 3'd0, 1'b0, 8'h00, 8'h00, 10'd0},
      '{ACTION_TICK, 8'h00, 8'h00, 8'h00, 8'h00,
        1'b1, 3'd2, 1'b0, 8'h0D, 8'h0D, 10'd428},
      // unknown fan code, knob steps of four are not steps
      '{ACTION_RESPONSE, FAN_UP_CODE + 8'd2, BUTTON_RELEASED,
        LEFT_KNOB_CENTER - 8'd4, RIGHT_KNOB_CENTER + 8'd4,
        1'b0, 3'd0, 1'b0, 8'h00, 8'h00, 10'd0},
      // fan up right after an unknown code does not count
      '{ACTION_RESPONSE, FAN_UP_CODE, BUTTON_RELEASED, 8'h00, 8'hFF,
        1'b0, 3'd0, 1'b0, 8'h00, 8'h00, 10'd0},
      '{ACTION_RESPONSE, BUTTON_RELEASED, 8'hFF, 8'hFF, 8'h00,
        1'b0, 3'd0, 1'b0, 8'h00, 8'h00, 10'd0},
      '{ACTION_RESPONSE, FAN_DOWN_CODE, BUTTON_RELEASED, 8'h00, 8'h00,
        1'b0, 3'd0, 1'b0, 8'h00, 8'h00, 10'd0},
      // tick carrying button codes that must not act
      '{ACTION_TICK, FAN_UP_CODE, DEFROST_PRESS_CODE,
        LEFT_KNOB_CENTER + 8'd1, RIGHT_KNOB_CENTER + 8'd1,
        1'b1, 3'd1, 1'b0, 8'h0D, 8'h0D, 10'd314},
      '{ACTION_RESPONSE, BUTTON_RELEASED, DEFROST_PRESS_CODE,
        LEFT_KNOB_CENTER + 8'd3, RIGHT_KNOB_CENTER + 8'd3,
        1'b0, 3'd0, 1'b0, 8'h00, 8'h00, 10'd0},
      '{ACTION_TICK, 8'h00, 8'h00, 8'h00, 8'h00,
        1'b1, 3'd1, 1'b1, 8'h10, 8'h10, 10'd314}
   };

   initial begin
      forever #4 clock = ~clock;
   end

   task automatic report_mismatch(input string what);
      mismatch_count++;
      // keep the log short when everything is broken
      if (mismatch_count <= 40)
         $display("mismatch at %0t: %s", $time, what);
   endtask

   // knob step: one to three above center raises, one to three below lowers
   function automatic logic [7:0] step_temp(input logic [7:0] t, input logic [7:0] code,
                                            input logic [7:0] center);
      logic [7:0] up;
      logic [7:0] dn;
      up = code - center;
      dn = center - code;
      if (up >= 8'd1 && up <= 8'd3)
         return t + up;
      else if (dn >= 8'd1 && dn <= 8'd3)
         return t - dn;
      return t;
   endfunction

   function automatic void note_wrap(input logic [7:0] old_t, input logic [7:0] new_t);
      int diff;
      diff = int'(new_t) - int'(old_t);
      if (diff > 3 || diff < -3)
         temp_wraps++;
   endfunction

   // advance the panel state for a response, or queue the 13 bytes of a tick
   function automatic void predict_request(input logic action, input logic [7:0] fan,
                                           input logic [7:0] def, input logic [7:0] lk,
                                           input logic [7:0] rk);
      logic [7:0]   run [RUN_BYTES];
      logic [7:0]   next_t;
      logic [9:0]   duty;
      bus_byte_type b;
      int           sum;
      int           i;
      if (action == ACTION_RESPONSE) begin
         next_t = step_temp(right_setting, rk, RIGHT_KNOB_CENTER);
         note_wrap(right_setting, next_t);
         right_setting = next_t;
         next_t = step_temp(left_setting, lk, LEFT_KNOB_CENTER);
         note_wrap(left_setting, next_t);
         left_setting = next_t;
         if (def == DEFROST_PRESS_CODE && prev_defrost_code == BUTTON_RELEASED) begin
            defrost_on = ~defrost_on;
            defrost_flips++;
         end
         // only an edge from released moves the fan, clamped at both ends
         if (fan == FAN_DOWN_CODE && prev_fan_code == BUTTON_RELEASED && fan_level_now != 3'd0)
            fan_level_now = fan_level_now - 3'd1;
         else if (fan == FAN_UP_CODE && prev_fan_code == BUTTON_RELEASED &&
                  fan_level_now != FAN_MAX)
            fan_level_now = fan_level_now + 3'd1;
         if (int'(fan_level_now) > top_level)
            top_level = int'(fan_level_now);
         prev_fan_code     = fan;
         prev_defrost_code = def;
      end else begin
         run[IDX_SYNC]  = SYNC_BYTE;
         run[IDX_PID]   = STATUS_PID;
         run[IDX_D0]    = DATA0_BYTE;
         run[IDX_D1]    = FAN_BASE | {5'd0, fan_level_now};
         run[IDX_D2]    = DATA2_BYTE;
         run[IDX_D3]    = defrost_on ? DEFROST_ON : DEFROST_OFF;
         run[IDX_D4]    = left_setting;
         run[IDX_D5]    = right_setting;
         run[IDX_D6]    = DATA6_BYTE;
         run[IDX_D7]    = DATA7_BYTE;
         // enhanced checksum: pid plus data, carry folded back in, inverted
         sum = 0;
         for (i = IDX_PID; i <= IDX_D7; i++) begin
            sum += run[i];
            if (sum > 255)
               sum -= 255;
         end
         run[IDX_CHK]   = 8'(255 - sum);
         run[IDX_HSYNC] = SYNC_BYTE;
         run[IDX_HPID]  = REQUEST_PID;
         duty = (fan_level_now == 3'd0) ? 10'd0 : 10'(800 * fan_level_now / 7 + 200);
         for (i = 0; i < RUN_BYTES; i++) begin
            b.tx_byte     = run[i];
            b.frame_start = (i == IDX_SYNC || i == IDX_HSYNC);
            b.fan_duty    = duty;
            b.last        = (i == IDX_HPID);
            expected_bytes.push_back(b);
         end
      end
   endfunction

   // mostly back to back, sometimes a short gap, now and then a long gap
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65)
         return 0;
      else if (r < 95)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic send_request(input logic action, input logic [7:0] fan, input logic [7:0] def,
                               input logic [7:0] lk, input logic [7:0] rk);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= action;
      req_tdata  <= {rk, lk, def, fan};
      do
         @(posedge clock);
      while (!req_tready);
      predict_request(action, fan, def, lk, rk);
      if (action == ACTION_TICK)
         ticks_sent++;
      else
         responses_sent++;
   endtask

   // a valid knob step, mostly in the drift direction, sometimes a stray code
   function automatic logic [7:0] pick_knob(input logic [7:0] center, input bit rising);
      int         r;
      logic [7:0] mag;
      r   = $urandom_range(0, 19);
      mag = 8'($urandom_range(1, 3));
      if (r < 2)
         return 8'($urandom_range(0, 255));
      else if (r < 15)
         return rising ? center + mag : center - mag;
      return rising ? center - mag : center + mag;
   endfunction

   // random part: well-formed press and release sequences whose drift flips
   // every phase so the fan hits both clamps and the temperatures wrap,
   // mixed with random ticks and noise responses
   task automatic run_random(input int count);
      int         i;
      int         r;
      bit         climb;
      logic [7:0] fan;
      logic [7:0] def;
      logic [7:0] last_fan;
      logic [7:0] last_def;
      last_fan = BUTTON_RELEASED;
      last_def = BUTTON_RELEASED;
      climb    = 1'b1;
      for (i = 0; i < count; i++) begin
         if (i % 30 == 0)
            climb = ((i / 30) % 2) == 0;
         r = $urandom_range(0, 19);
         if (r < 5) begin
            send_request(ACTION_TICK, 8'($urandom_range(0, 255)),
                         8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                         8'($urandom_range(0, 255)));
         end else if (r < 8) begin
            fan = 8'($urandom_range(0, 255));
            def = 8'($urandom_range(0, 255));
            send_request(ACTION_RESPONSE, fan, def, 8'($urandom_range(0, 255)),
                         8'($urandom_range(0, 255)));
            last_fan = fan;
            last_def = def;
         end else begin
            if (last_fan != BUTTON_RELEASED)
               fan = ($urandom_range(0, 5) == 0) ? last_fan : BUTTON_RELEASED;
            else if ($urandom_range(0, 4) == 0)
               fan = BUTTON_RELEASED;
            else if ($urandom_range(0, 3) != 0)
               fan = climb ? FAN_UP_CODE : FAN_DOWN_CODE;
            else
               fan = climb ? FAN_DOWN_CODE : FAN_UP_CODE;
            if (last_def != BUTTON_RELEASED)
               def = BUTTON_RELEASED;
            else
               def = ($urandom_range(0, 3) == 0) ? DEFROST_PRESS_CODE : BUTTON_RELEASED;
            // left drifts against the fan direction, right with it
            send_request(ACTION_RESPONSE, fan, def, pick_knob(LEFT_KNOB_CENTER, !climb),
                         pick_knob(RIGHT_KNOB_CENTER, climb));
            last_fan = fan;
            last_def = def;
         end
      end
   endtask

   // receiver: ready bursts, short and occasional long stalls, one long hold-off
   initial begin
      int stall;
      wait (reset == 1'b0);
      forever begin
         if (!hold_done && bytes_seen >= HOLD_AFTER) begin
            // requests keep coming while the output is blocked, so the tick
            // queue fills and the block has to stall its input
            hold_done = 1;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else if ($urandom_range(0, 2) != 0) begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b0;
            stall = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                : $urandom_range(1, 3);
            repeat (stall) @(posedge clock);
         end
      end
   end

   // output monitor: every accepted byte against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         bytes_seen++;
         if (expected_bytes.size() == 0) begin
            report_mismatch($sformatf("byte %h with nothing expected", rsp_tdata[7:0]));
         end else begin
            want = expected_bytes.pop_front();
            if (rsp_tdata[7:0] !== want.tx_byte)
               report_mismatch($sformatf("tx_byte %h, expected %h", rsp_tdata[7:0],
                                         want.tx_byte));
            if (rsp_tuser !== want.frame_start)
               report_mismatch($sformatf("frame_start %b, expected %b", rsp_tuser,
                                         want.frame_start));
            if (rsp_tdata[17:8] !== want.fan_duty)
               report_mismatch($sformatf("fan_duty %0d, expected %0d", rsp_tdata[17:8],
                                         want.fan_duty));
            if (rsp_tlast !== want.last)
               report_mismatch($sformatf("last %b, expected %b", rsp_tlast, want.last));
            if (rsp_tdata[23:18] !== 6'd0)
               report_mismatch($sformatf("tdata fill bits %b not zero", rsp_tdata[23:18]));
         end
      end
   end

   // stimulus and end of run
   initial begin
      int k;
      int base;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      for (k = 0; k < $size(directed_rows); k++) begin
         send_request(directed_rows[k].action, directed_rows[k].fan, directed_rows[k].defrost,
                      directed_rows[k].left_knob, directed_rows[k].right_knob);
         // hand-written state replaces the predicted frame contents
         if (directed_rows[k].typed) begin
            base = expected_bytes.size() - RUN_BYTES;
            expected_bytes[base + IDX_D1].tx_byte = FAN_BASE | {5'd0, directed_rows[k].level};
            expected_bytes[base + IDX_D3].tx_byte =
               directed_rows[k].defrost_on ? DEFROST_ON : DEFROST_OFF;
            expected_bytes[base + IDX_D4].tx_byte = directed_rows[k].left_t;
            expected_bytes[base + IDX_D5].tx_byte = directed_rows[k].right_t;
            for (int j = 0; j < RUN_BYTES; j++)
               expected_bytes[base + j].fan_duty = directed_rows[k].duty;
         end
      end

      run_random(RANDOM_ITEMS);
      req_tvalid <= 1'b0;

      wait (expected_bytes.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d requests: %0d ticks, %0d panel responses, %0d bus bytes checked",
               ticks_sent + responses_sent, ticks_sent, responses_sent, bytes_seen);
      $display("fan reached level %0d, %0d defrost toggles, %0d temperature wraps",
               top_level, defrost_flips, temp_wraps);
      if (mismatch_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #5ms;
      $display("timeout with %0d bytes still expected", expected_bytes.size());
      $display("Regression FAIL");
      $finish;
   end

endmodule
